// ----- hdl/timestamped_frame_buffer_lookup_top_assert.svh -----
// Assertion shorthands, clocked on clk and disabled while arst_n is low.
`ifndef TIMESTAMPED_FRAME_BUFFER_LOOKUP_TOP_ASSERT_SVH
`define TIMESTAMPED_FRAME_BUFFER_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication.
`define TFBL_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TFBL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tfbl_pkg.sv -----
package tfbl_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned HANDLE_W  = 16;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_W     = 5;
	localparam int unsigned COUNT_W   = 5;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [TIME_W-1:0]   key_time;
		logic [HANDLE_W-1:0] entry_handle;
		logic [TIME_W-1:0]   tolerance;
	} tfbl_in_t;

	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] found_handle;
		logic [TIME_W-1:0]   found_time;
		logic [COUNT_W-1:0]  entry_count;
		logic [TIME_W-1:0]   oldest_time;
	} tfbl_out_t;

	typedef struct packed {
		logic [TIME_W-1:0]   frame_time;
		logic [HANDLE_W-1:0] handle;
	} tfbl_rec_t;

	typedef struct packed {
		logic load;
		logic add_wr;
		logic scan_rd;
		logic commit;
		logic head_rd;
		logic out_ld;
	} tfbl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              empty;
		logic              scan_last;
		logic              pipe_busy;
	} tfbl_stat_t;

endpackage

// ----- hdl/tfbl_ram.sv -----
module tfbl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/tfbl_ctrl.sv -----
module tfbl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output tfbl_pkg::tfbl_cmd_t   ctl,
	input  tfbl_pkg::tfbl_stat_t  stat
);
	import tfbl_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_ADD      = 3'd2;
	localparam logic [2:0] ST_SCAN     = 3'd3;
	localparam logic [2:0] ST_DRAIN    = 3'd4;
	localparam logic [2:0] ST_HEAD     = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.mode)
					MODE_ADD: state_d = ST_ADD;
					MODE_REMOVE, MODE_FIND: state_d = stat.empty ? ST_HEAD : ST_SCAN;
					default: state_d = ST_HEAD;
				endcase
			end
			ST_ADD: begin
				ctl.add_wr = 1'b1;
				state_d    = ST_HEAD;
			end
			ST_SCAN: begin
				ctl.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last compaction write and best-match update
				if (!stat.pipe_busy) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				ctl.head_rd = 1'b1;
				ctl.commit  = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				ctl.out_ld = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- hdl/tfbl_dp.sv -----
module tfbl_dp #(
	parameter int unsigned DEPTH = tfbl_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tfbl_pkg::tfbl_cmd_t          ctl,
	output tfbl_pkg::tfbl_stat_t         stat,
	input  tfbl_pkg::tfbl_in_t           cmd,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tfbl_pkg::CFG_W-1:0]   cfg_data,
	output logic                         done,
	output tfbl_pkg::tfbl_out_t          result
);
	import tfbl_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	tfbl_in_t         item_q;
	logic [CFG_W-1:0] max_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_idx_q;
	logic [CW-1:0]    wr_idx_q;
	logic             v_s1;
	logic             v_s2;
	logic [TIME_W-1:0] d_s2;
	tfbl_rec_t        rec_s2;
	logic             best_v_q;
	logic [TIME_W-1:0] best_d_q;
	tfbl_rec_t        best_rec_q;
	tfbl_out_t        result_q;
	logic             done_q;

	logic [LW-1:0]    max_ext;
	logic [LW-1:0]    lim_l;
	logic [CW-1:0]    lim;
	logic [AW-1:0]    add_head;
	logic [CW-1:0]    add_cnt;
	logic             keep;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	tfbl_rec_t        ram_wdata;
	logic [AW-1:0]    ram_raddr;
	tfbl_rec_t        ram_rdata;
	logic [TIME_W-1:0] abs_d;
	logic             hit;

	assign cfg_ready = 1'b1;

	// clamp the configured limit to 1..DEPTH
	always_comb begin
		max_ext = LW'(max_q);
		if (max_ext == '0) begin
			lim_l = LW'(1);
		end else if (max_ext > LW'(DEPTH)) begin
			lim_l = LW'(DEPTH);
		end else begin
			lim_l = max_ext;
		end
		lim = lim_l[CW-1:0];
	end

	// drop the oldest frames at once by advancing the head
	always_comb begin
		if (count_q >= lim) begin
			add_head = wrap_add(head_q, count_q - lim + CW'(1));
			add_cnt  = lim - CW'(1);
		end else begin
			add_head = head_q;
			add_cnt  = count_q;
		end
	end

	assign keep = v_s1 && (item_q.mode == MODE_REMOVE) && (ram_rdata.frame_time > item_q.key_time);

	always_comb begin
		if (ctl.add_wr) begin
			ram_we    = 1'b1;
			ram_waddr = wrap_add(add_head, add_cnt);
			ram_wdata = '{frame_time: item_q.key_time, handle: item_q.entry_handle};
		end else begin
			ram_we    = keep;
			ram_waddr = wrap_add(head_q, wr_idx_q);
			ram_wdata = ram_rdata;
		end
	end

	assign ram_raddr = ctl.head_rd ? head_q : wrap_add(head_q, rd_idx_q);

	tfbl_ram #(
		.WIDTH($bits(tfbl_rec_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign abs_d = (ram_rdata.frame_time >= item_q.key_time) ?
		(ram_rdata.frame_time - item_q.key_time) : (item_q.key_time - ram_rdata.frame_time);

	// a zero tolerance asks for an exact match, i.e. a zero distance
	assign hit = best_v_q && ((item_q.tolerance == '0) ? (best_d_q == '0) :
		(best_d_q < item_q.tolerance));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		d_s2   <= abs_d;
		rec_s2 <= ram_rdata;
		if (v_s2 && (!best_v_q || (d_s2 < best_d_q))) begin
			best_d_q   <= d_s2;
			best_rec_q <= rec_s2;
		end
		if (ctl.out_ld) begin
			result_q.found        <= hit;
			result_q.found_handle <= hit ? best_rec_q.handle : '0;
			result_q.found_time   <= hit ? best_rec_q.frame_time : '0;
			result_q.entry_count  <= COUNT_W'(count_q);
			result_q.oldest_time  <= (count_q == '0) ? '0 : ram_rdata.frame_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_ENTRIES_RST;
			head_q   <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			best_v_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (ctl.load) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				best_v_q <= 1'b0;
			end else begin
				if (ctl.scan_rd) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (keep) begin
					wr_idx_q <= wr_idx_q + CW'(1);
				end
				if (v_s2) begin
					best_v_q <= 1'b1;
				end
			end
			if (ctl.add_wr) begin
				head_q  <= add_head;
				count_q <= add_cnt + CW'(1);
			end
			if (ctl.commit && (item_q.mode == MODE_REMOVE)) begin
				count_q <= wr_idx_q;
			end
			v_s1   <= ctl.scan_rd;
			v_s2   <= v_s1 && (item_q.mode == MODE_FIND);
			done_q <= ctl.out_ld;
		end
	end

	assign stat.mode      = item_q.mode;
	assign stat.empty     = (count_q == '0);
	assign stat.scan_last = (rd_idx_q == (count_q - CW'(1)));
	assign stat.pipe_busy = v_s1 || v_s2;

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hdl/timestamped_frame_buffer_lookup_top.sv -----
// Frame buffer with nearest-timestamp lookup. Pulse start while busy is low to
// hand in one command; exactly one result follows on result, valid only in the
// single cycle that done is high, and it cannot be held off, so capture it then.
// A remove or a find walks the stored frames one per cycle through the single
// read port of the frame memory, and skips the walk when the buffer is empty.
// A new command may be started in the cycle done is high.
// max_entries may be written over the cfg channel at any idle time; lowering it
// trims the oldest frames only at the next add.
`include "timestamped_frame_buffer_lookup_top_assert.svh"

module timestamped_frame_buffer_lookup_top #(
	parameter int unsigned DEPTH = tfbl_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tfbl_pkg::tfbl_in_t          cmd,
	output logic                        done,
	output tfbl_pkg::tfbl_out_t         result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tfbl_pkg::CFG_W-1:0]  cfg_data
);
	import tfbl_pkg::*;

	tfbl_cmd_t  ctl;
	tfbl_stat_t stat;

	tfbl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.ctl   (ctl),
		.stat  (stat)
	);

	tfbl_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.cmd      (cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	`TFBL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
	`TFBL_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")
	`TFBL_ASSERT_NOW(a_miss_zero, done && !result.found,
		(result.found_handle == '0) && (result.found_time == '0), "miss with nonzero frame")
	`TFBL_ASSERT_NOW(a_empty_oldest, done && (result.entry_count == '0),
		result.oldest_time == '0, "empty buffer reports nonzero oldest time")

endmodule

// ----- bench/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tfbl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam int unsigned       CYCLE_LIMIT = 400000;
	localparam int unsigned       PHASE_ITEMS = 75;

	// Predicts every result of the frame buffer and holds the ones still to come.
	class frame_lookup_board;
		logic [TIME_W-1:0]   times [DEPTH_DEF];
		logic [HANDLE_W-1:0] handles [DEPTH_DEF];
		int unsigned         held;
		logic [CFG_W-1:0]    max_entries;
		tfbl_out_t           pending [$];
		int unsigned         errors, checked, hits;
		int unsigned         per_mode [4];

		function new();
			held = 0;
			max_entries = MAX_ENTRIES_RST;
			errors = 0;
			checked = 0;
			hits = 0;
			foreach (per_mode[i]) per_mode[i] = 0;
		endfunction

		function logic [TIME_W-1:0] time_at(int unsigned idx);
			return times[idx];
		endfunction

		function void note(tfbl_in_t c);
			tfbl_out_t   r;
			int unsigned lim, w, best;
			logic [TIME_W-1:0] d, best_d;
			r = '0;
			per_mode[c.mode]++;
			lim = max_entries;
			if (lim < 1) lim = 1;
			if (lim > DEPTH_DEF) lim = DEPTH_DEF;
			case (c.mode)
			MODE_ADD: begin
				// drop the oldest until the new frame fits under the limit
				while (held >= lim) begin
					for (int i = 1; i < held; i++) begin
						times[i-1] = times[i];
						handles[i-1] = handles[i];
					end
					held--;
				end
				if (held < DEPTH_DEF) begin
					times[held] = c.key_time;
					handles[held] = c.entry_handle;
					held++;
				end
			end
			MODE_REMOVE: begin
				w = 0;
				for (int i = 0; i < held; i++) begin
					if (times[i] > c.key_time) begin
						times[w] = times[i];
						handles[w] = handles[i];
						w++;
					end
				end
				held = w;
			end
			MODE_FIND: begin
				if (held > 0 && c.tolerance == 0) begin
					for (int i = 0; i < held; i++) begin
						if (times[i] == c.key_time) begin
							r.found = 1'b1;
							r.found_handle = handles[i];
							r.found_time = times[i];
							break;
						end
					end
				end else if (held > 0) begin
					best = 0;
					best_d = (times[0] > c.key_time) ? times[0] - c.key_time
						: c.key_time - times[0];
					for (int i = 1; i < held; i++) begin
						d = (times[i] > c.key_time) ? times[i] - c.key_time
							: c.key_time - times[i];
						if (d < best_d) begin
							best_d = d;
							best = i;
						end
					end
					if (best_d < c.tolerance) begin
						r.found = 1'b1;
						r.found_handle = handles[best];
						r.found_time = times[best];
					end
				end
			end
			default: begin
			end
			endcase
			r.entry_count = COUNT_W'(held);
			r.oldest_time = (held > 0) ? times[0] : '0;
			if (r.found) hits++;
			pending = {pending, r};
		endfunction

		function void compare(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check(tfbl_out_t got);
			tfbl_out_t want;
			if (pending.size() == 0) begin
				$error("result transfer with no command outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			compare("found", want.found, got.found);
			compare("found_handle", want.found_handle, got.found_handle);
			compare("found_time", want.found_time, got.found_time);
			compare("entry_count", want.entry_count, got.entry_count);
			compare("oldest_time", want.oldest_time, got.oldest_time);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	tfbl_in_t         cmd = '0;
	logic             done;
	tfbl_out_t        result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	frame_lookup_board sb = new();
	int unsigned       cycle_count = 0;
	int unsigned       limit_writes = 0;
	bit                steady = 1'b0;
	logic [TIME_W-1:0] stamp;

	timestamped_frame_buffer_lookup_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done) sb.check(result);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timestamped_frame_buffer_lookup_top verification failed");
		$finish;
	end

	function automatic tfbl_in_t make_cmd(logic [MODE_W-1:0] m, logic [TIME_W-1:0] k,
			logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] t);
		tfbl_in_t c;
		c.mode = m;
		c.key_time = k;
		c.entry_handle = h;
		c.tolerance = t;
		return c;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		return {$urandom(), $urandom()};
	endfunction

	// Hold start until the command is taken, then idle at random.
	task automatic send(tfbl_in_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note(c);
		if (!steady && $urandom_range(0, 99) < 26) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] v);
		if ($urandom_range(0, 99) < 26) repeat ($urandom_range(1, 6)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.max_entries = v;
		limit_writes++;
	endtask

	// Mostly camera-like traffic: rising stamps, lookups and purges near stored frames.
	task automatic run_phase(int unsigned n);
		int unsigned       pick, idx;
		logic [TIME_W-1:0] key, tol;
		for (int unsigned k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			idx = (sb.held > 0) ? $urandom_range(0, sb.held - 1) : 0;
			if (pick < 45) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) stamp = stamp + $urandom_range(1, 40000);
				else if (pick == 8) stamp = stamp - $urandom_range(1, 40000);
				else if (pick == 9) stamp = rand_time();
				send(make_cmd(MODE_ADD, stamp, $urandom(), rand_time()));
			end else if (pick < 80) begin
				key = (sb.held > 0) ? sb.time_at(idx) : stamp;
				pick = $urandom_range(0, 9);
				if (pick >= 7) key = key + $urandom_range(1, 40000);
				else if (pick >= 4) key = key - $urandom_range(1, 40000);
				pick = $urandom_range(0, 19);
				if (pick < 5) tol = '0;
				else if (pick < 12) tol = $urandom_range(1, 50000);
				else if (pick < 16) tol = rand_time();
				else if (pick < 18) tol = TIME_MAX;
				else tol = 1;
				send(make_cmd(MODE_FIND, key, $urandom(), tol));
			end else if (pick < 90) begin
				key = (sb.held > 0) ? sb.time_at(idx) + $urandom_range(0, 2) - 1 : rand_time();
				send(make_cmd(MODE_REMOVE, key, $urandom(), rand_time()));
			end else begin
				tol = ($urandom_range(0, 3) == 0) ? '0 : rand_time();
				send(make_cmd($urandom_range(0, 3), rand_time(), $urandom(), tol));
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] limits [8];
		limits = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17, 5'd2};
		stamp = rand_time();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, unused mode
		send(make_cmd(MODE_FIND, '0, '0, '0));
		send(make_cmd(MODE_REMOVE, TIME_MAX, '1, TIME_MAX));
		send(make_cmd(MODE_UNUSED, TIME_MAX, '1, TIME_MAX));
		// duplicate stamps: exact match and tie both pick the oldest
		send(make_cmd(MODE_ADD, 64'd100, 16'hFFFF, '0));
		send(make_cmd(MODE_ADD, 64'd200, 16'h0000, TIME_MAX));
		send(make_cmd(MODE_ADD, 64'd200, 16'h1234, '0));
		send(make_cmd(MODE_FIND, 64'd200, '0, '0));
		send(make_cmd(MODE_FIND, 64'd150, '0, 64'd100));
		send(make_cmd(MODE_FIND, 64'd150, '0, 64'd50));
		send(make_cmd(MODE_FIND, 64'd201, '0, '0));
		send(make_cmd(MODE_ADD, TIME_MAX, 16'hA5A5, '0));
		send(make_cmd(MODE_ADD, '0, 16'h5A5A, '0));
		send(make_cmd(MODE_FIND, TIME_MAX, '0, TIME_MAX));
		send(make_cmd(MODE_FIND, '0, '0, 64'd1));
		send(make_cmd(MODE_UNUSED, 64'd200, 16'hFFFF, 64'd1));
		send(make_cmd(MODE_REMOVE, 64'd100, '0, '0));
		send(make_cmd(MODE_REMOVE, 64'd199, '0, '0));
		send(make_cmd(MODE_FIND, 64'h8000_0000_0000_0000, '0, TIME_MAX));
		send(make_cmd(MODE_REMOVE, TIME_MAX, '0, '0));
		send(make_cmd(MODE_FIND, 64'd5, '0, TIME_MAX));
		// distance of all ones is not strictly below a tolerance of all ones
		send(make_cmd(MODE_ADD, '0, 16'h0001, '0));
		send(make_cmd(MODE_FIND, TIME_MAX, '0, TIME_MAX));

		foreach (limits[p]) begin
			drain();
			write_limit(limits[p]);
			steady = (p == 3);
			run_phase(PHASE_ITEMS);
		end
		steady = 1'b0;
		drain();
		repeat (30) @(posedge clk);

		$display("Ran %0d commands (%0d add, %0d remove, %0d find, %0d unused), %0d lookup hits,",
			sb.per_mode[MODE_ADD] + sb.per_mode[MODE_REMOVE] + sb.per_mode[MODE_FIND]
			+ sb.per_mode[MODE_UNUSED], sb.per_mode[MODE_ADD], sb.per_mode[MODE_REMOVE],
			sb.per_mode[MODE_FIND], sb.per_mode[MODE_UNUSED], sb.hits);
		$display("over %0d max_entries writes; %0d results compared, %0d mismatches.",
			limit_writes, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("timestamped_frame_buffer_lookup_top verification clean");
		end else begin
			$display("timestamped_frame_buffer_lookup_top verification failed");
		end
		$finish;
	end
endmodule
